/* hdl/dlts_pkg.sv */
// Package for the delta-list task scheduler.
// Holds command and status codes, field widths and parameter defaults.
// No dependencies.
`default_nettype none

package dlts_pkg;

  // Field widths of the words on both channels and of the queue entries.
  localparam int unsigned CmdW    = 2;
  localparam int unsigned IdW     = 8;
  localparam int unsigned InDlyW  = 16;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned StatW   = 2;
  localparam int unsigned RunsW   = 8;

  // Parameter defaults.
  localparam int unsigned MaxTasksDef  = 16;
  localparam int unsigned DelayBitsDef = 16;

  // Most result words one dispatch may produce.
  localparam int unsigned MaxResults = 16;

  // Command codes.
  localparam logic [CmdW-1:0] CMD_TICK = 2'd0;
  localparam logic [CmdW-1:0] CMD_ADD  = 2'd1;
  localparam logic [CmdW-1:0] CMD_DEL  = 2'd2;
  localparam logic [CmdW-1:0] CMD_DISP = 2'd3;

  // Status codes.
  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatW-1:0] ST_BAD   = 2'd2;
  localparam logic [StatW-1:0] ST_NONE  = 2'd3;

endpackage

`default_nettype wire

/* hdl/dlts_if.sv */
// Channel interfaces of the delta-list task scheduler.
// Depends on dlts_pkg for the field widths.
`default_nettype none

interface dlts_in_if;
  logic                         valid;
  logic                         ready;
  logic [dlts_pkg::CmdW-1:0]    cmd;
  logic [dlts_pkg::IdW-1:0]     task_id;
  logic [dlts_pkg::InDlyW-1:0]  delay;
  logic [dlts_pkg::InDlyW-1:0]  period;
  logic [dlts_pkg::SlotW-1:0]   slot;

  modport source (output valid, cmd, task_id, delay, period, slot, input ready);
  modport sink   (input valid, cmd, task_id, delay, period, slot, output ready);
endinterface

interface dlts_out_if;
  logic                        valid;
  logic                        ready;
  logic [dlts_pkg::StatW-1:0]  status;
  logic [dlts_pkg::SlotW-1:0]  slot_out;
  logic [dlts_pkg::IdW-1:0]    run_id;
  logic                        last;

  modport source (output valid, status, slot_out, run_id, last, input ready);
  modport sink   (input valid, status, slot_out, run_id, last, output ready);
endinterface

`default_nettype wire

/* hdl/delta_list_task_scheduler_unit.sv */
// Delta-list task scheduler, top level.
// Depends on dlts_pkg and the channel interfaces in dlts_if.sv.
//
// Usage: one command word enters on in_i (tick, add, delete, dispatch) and
// the block answers with one or more result words on out_o; the final word
// of each command has last set. Commands are handled one at a time: in_i is
// ready only while the sequencer is idle.
// All queue entries live in one synchronous memory with one read and one
// write port. Every entry visited takes a read, then a use or write step,
// so the memory port sets the pace of each command:
//   add       walks the list, then shifts the tail up,
//   delete    shifts every entry above the slot down,
//   tick      reads each skipped entry, plus remove and insert for a
//             periodic task that fires,
//   dispatch  reads each entry scanned, plus one removal per finished
//             one-shot task.
// Reset clears the task count and the sequencer; memory contents are never
// read above the count, so no clearing pass is needed.
// A stalled receiver holds the result register; the sequencer waits on it
// only when it has a new word to hand over.
`default_nettype none

module delta_list_task_scheduler_unit #(
  parameter int unsigned MAX_TASKS  = dlts_pkg::MaxTasksDef,
  parameter int unsigned DELAY_BITS = dlts_pkg::DelayBitsDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  dlts_in_if.sink     in_i,
  dlts_out_if.source  out_o
);

  localparam int unsigned DW = DELAY_BITS;
  localparam int unsigned AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned IW = $clog2(MAX_TASKS + 1);
  localparam int unsigned NW = $clog2(dlts_pkg::MaxResults + 1);
  localparam logic [DW-1:0] DMAX = {DW{1'b1}};
  localparam logic [IW-1:0] CNT_MAX = IW'(MAX_TASKS);

  typedef struct packed {
    logic [dlts_pkg::IdW-1:0]   tid;
    logic [DW-1:0]              delta;
    logic [DW-1:0]              period;
    logic [dlts_pkg::RunsW-1:0] runs;
  } entry_t;

  // Sequencer state codes.
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_IRD   = 5'd1;
  localparam logic [4:0] S_IEV   = 5'd2;
  localparam logic [4:0] S_SRD   = 5'd3;
  localparam logic [4:0] S_SEV   = 5'd4;
  localparam logic [4:0] S_IWR   = 5'd5;
  localparam logic [4:0] S_RRD   = 5'd6;
  localparam logic [4:0] S_REV   = 5'd7;
  localparam logic [4:0] S_MRD   = 5'd8;
  localparam logic [4:0] S_MEV   = 5'd9;
  localparam logic [4:0] S_RDONE = 5'd10;
  localparam logic [4:0] S_TRD   = 5'd11;
  localparam logic [4:0] S_TEV   = 5'd12;
  localparam logic [4:0] S_DRD   = 5'd13;
  localparam logic [4:0] S_DEV   = 5'd14;
  localparam logic [4:0] S_DEND  = 5'd15;
  localparam logic [4:0] S_DDR   = 5'd16;
  localparam logic [4:0] S_FIN   = 5'd17;

  // Queue memory.
  entry_t mem [MAX_TASKS];
  entry_t rdata_q;
  logic             re, we;
  logic [AW-1:0]    raddr, waddr;
  entry_t           wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // Control and working registers.
  logic [4:0]                   st_q, st_d;
  logic [IW-1:0]                cnt_q, cnt_d;
  logic [IW-1:0]                idx_q, idx_d;
  logic [IW-1:0]                pos_q, pos_d;
  logic [DW-1:0]                dly_q, dly_d;
  logic [DW-1:0]                sd_q, sd_d;
  entry_t                       nw_q, nw_d;
  logic [dlts_pkg::CmdW-1:0]    cmd_q, cmd_d;
  logic [MAX_TASKS-1:0]         drop_q, drop_d;
  logic [NW-1:0]                n_q, n_d;
  logic [dlts_pkg::StatW-1:0]   rs_st_q, rs_st_d;
  logic [dlts_pkg::SlotW-1:0]   rs_sl_q, rs_sl_d;
  // Dispatch word held back until it is known whether it is the last one.
  logic                         pv_q, pv_d;
  logic [dlts_pkg::SlotW-1:0]   psl_q, psl_d;
  logic [dlts_pkg::IdW-1:0]     pid_q, pid_d;
  // Result register.
  logic                         ov_q, ov_d;
  logic [dlts_pkg::StatW-1:0]   ost_q, ost_d;
  logic [dlts_pkg::SlotW-1:0]   osl_q, osl_d;
  logic [dlts_pkg::IdW-1:0]     oid_q, oid_d;
  logic                         olast_q, olast_d;

  logic in_acc;
  logic [DW-1:0] d_sat, p_sat;
  logic [DW:0]   dsum;
  logic [IW-1:0] idx_m1, idx_p1;

  assign in_i.ready = (st_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign out_o.valid    = ov_q;
  assign out_o.status   = ost_q;
  assign out_o.slot_out = osl_q;
  assign out_o.run_id   = oid_q;
  assign out_o.last     = olast_q;

  // Saturate the input delays to the delta width.
  assign d_sat = (32'(in_i.delay) > 32'(DMAX)) ? DMAX : DW'(in_i.delay);
  assign p_sat = (32'(in_i.period) > 32'(DMAX)) ? DMAX : DW'(in_i.period);

  assign dsum   = {1'b0, rdata_q.delta} + {1'b0, sd_q};
  assign idx_m1 = idx_q - IW'(1);
  assign idx_p1 = idx_q + IW'(1);

  // Sequencer.
  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    pos_d   = pos_q;
    dly_d   = dly_q;
    sd_d    = sd_q;
    nw_d    = nw_q;
    cmd_d   = cmd_q;
    drop_d  = drop_q;
    n_d     = n_q;
    rs_st_d = rs_st_q;
    rs_sl_d = rs_sl_q;
    pv_d    = pv_q;
    psl_d   = psl_q;
    pid_d   = pid_q;
    ov_d    = ov_q && !out_o.ready;
    ost_d   = ost_q;
    osl_d   = osl_q;
    oid_d   = oid_q;
    olast_d = olast_q;
    re      = 1'b0;
    raddr   = idx_q[AW-1:0];
    we      = 1'b0;
    waddr   = idx_q[AW-1:0];
    wdata   = rdata_q;

    unique case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d   = in_i.cmd;
          rs_st_d = dlts_pkg::ST_OK;
          rs_sl_d = '0;
          idx_d   = '0;
          unique case (in_i.cmd)
            dlts_pkg::CMD_TICK: begin
              st_d = (cnt_q == '0) ? S_FIN : S_TRD;
            end
            dlts_pkg::CMD_ADD: begin
              if (cnt_q == CNT_MAX) begin
                rs_st_d = dlts_pkg::ST_FULL;
                st_d    = S_FIN;
              end else begin
                nw_d  = '{tid: in_i.task_id, delta: '0, period: p_sat, runs: '0};
                dly_d = d_sat;
                st_d  = S_IRD;
              end
            end
            dlts_pkg::CMD_DEL: begin
              if (8'(in_i.slot) >= 8'(cnt_q)) begin
                rs_st_d = dlts_pkg::ST_BAD;
                st_d    = S_FIN;
              end else begin
                pos_d = IW'(in_i.slot);
                st_d  = S_RRD;
              end
            end
            dlts_pkg::CMD_DISP: begin
              drop_d = '0;
              n_d    = '0;
              st_d   = S_DRD;
            end
            default: st_d = S_FIN;
          endcase
        end
      end

      // Insert: walk the list subtracting passed deltas.
      S_IRD: begin
        if (idx_q == cnt_q) begin
          pos_d = idx_q;
          st_d  = S_IWR;
        end else begin
          re   = 1'b1;
          st_d = S_IEV;
        end
      end
      S_IEV: begin
        if (dly_q >= rdata_q.delta) begin
          dly_d = dly_q - rdata_q.delta;
          idx_d = idx_p1;
          st_d  = S_IRD;
        end else begin
          pos_d = idx_q;
          idx_d = cnt_q;
          st_d  = S_SRD;
        end
      end
      // Shift entries up by one, from the tail down to the insert point.
      S_SRD: begin
        re    = 1'b1;
        raddr = idx_m1[AW-1:0];
        st_d  = S_SEV;
      end
      S_SEV: begin
        we = 1'b1;
        if (idx_m1 == pos_q) begin
          wdata.delta = rdata_q.delta - dly_q;
          st_d        = S_IWR;
        end else begin
          idx_d = idx_m1;
          st_d  = S_SRD;
        end
      end
      S_IWR: begin
        we          = 1'b1;
        waddr       = pos_q[AW-1:0];
        wdata       = nw_q;
        wdata.delta = dly_q;
        cnt_d       = cnt_q + IW'(1);
        if (cmd_q == dlts_pkg::CMD_ADD) begin
          rs_sl_d = dlts_pkg::SlotW'(pos_q);
        end
        st_d = S_FIN;
      end

      // Remove: fold the delta into the successor and shift the rest down.
      S_RRD: begin
        re    = 1'b1;
        raddr = pos_q[AW-1:0];
        st_d  = S_REV;
      end
      S_REV: begin
        sd_d  = rdata_q.delta;
        idx_d = pos_q;
        st_d  = ((pos_q + IW'(1)) < cnt_q) ? S_MRD : S_RDONE;
      end
      S_MRD: begin
        re    = 1'b1;
        raddr = idx_p1[AW-1:0];
        st_d  = S_MEV;
      end
      S_MEV: begin
        we = 1'b1;
        if (idx_q == pos_q) begin
          wdata.delta = dsum[DW] ? DMAX : dsum[DW-1:0];
        end
        if ((IW'(idx_q + IW'(2)) < cnt_q) && (idx_q + IW'(2) > idx_q)) begin
          idx_d = idx_p1;
          st_d  = S_MRD;
        end else begin
          st_d = S_RDONE;
        end
      end
      S_RDONE: begin
        cnt_d = cnt_q - IW'(1);
        unique case (cmd_q)
          dlts_pkg::CMD_TICK: begin
            idx_d = '0;
            st_d  = S_IRD;
          end
          dlts_pkg::CMD_DISP: begin
            idx_d = pos_q;
            st_d  = S_DDR;
          end
          default: st_d = S_FIN;
        endcase
      end

      // Tick: skip fired one-shots, then count down or fire the head.
      S_TRD: begin
        if (idx_q == cnt_q) begin
          st_d = S_FIN;
        end else begin
          re   = 1'b1;
          st_d = S_TEV;
        end
      end
      S_TEV: begin
        if (rdata_q.period == '0 && rdata_q.runs != '0) begin
          idx_d = idx_p1;
          st_d  = S_TRD;
        end else if (rdata_q.delta != '0) begin
          we          = 1'b1;
          wdata.delta = rdata_q.delta - DW'(1);
          st_d        = S_FIN;
        end else begin
          wdata.runs = (rdata_q.runs == '1) ? rdata_q.runs : rdata_q.runs + 8'd1;
          if (rdata_q.period == '0) begin
            we   = 1'b1;
            st_d = S_FIN;
          end else begin
            nw_d  = wdata;
            dly_d = rdata_q.period;
            pos_d = idx_q;
            st_d  = S_RRD;
          end
        end
      end

      // Dispatch: scan for pending runs, one word per ready task.
      S_DRD: begin
        if (idx_q == cnt_q || n_q == NW'(dlts_pkg::MaxResults)) begin
          st_d = S_DEND;
        end else begin
          re   = 1'b1;
          st_d = S_DEV;
        end
      end
      S_DEV: begin
        if (rdata_q.runs == '0) begin
          idx_d = idx_p1;
          st_d  = S_DRD;
        end else if (!(pv_q && ov_q)) begin
          if (pv_q) begin
            ov_d    = 1'b1;
            ost_d   = dlts_pkg::ST_OK;
            osl_d   = psl_q;
            oid_d   = pid_q;
            olast_d = 1'b0;
          end
          pv_d       = 1'b1;
          psl_d      = dlts_pkg::SlotW'(idx_q);
          pid_d      = rdata_q.tid;
          we         = 1'b1;
          wdata.runs = rdata_q.runs - 8'd1;
          if (rdata_q.runs == 8'd1 && rdata_q.period == '0) begin
            drop_d[idx_q[AW-1:0]] = 1'b1;
          end
          n_d   = n_q + NW'(1);
          idx_d = idx_p1;
          st_d  = S_DRD;
        end
      end
      S_DEND: begin
        if (!pv_q) begin
          rs_st_d = dlts_pkg::ST_NONE;
          st_d    = S_FIN;
        end else if (!ov_q) begin
          ov_d    = 1'b1;
          ost_d   = dlts_pkg::ST_OK;
          osl_d   = psl_q;
          oid_d   = pid_q;
          olast_d = 1'b1;
          pv_d    = 1'b0;
          idx_d   = cnt_q;
          st_d    = S_DDR;
        end
      end
      // Remove finished one-shot tasks from the back to the front.
      S_DDR: begin
        if (idx_q == '0) begin
          st_d = S_IDLE;
        end else if (drop_q[idx_m1[AW-1:0]]) begin
          drop_d[idx_m1[AW-1:0]] = 1'b0;
          pos_d = idx_m1;
          st_d  = S_RRD;
        end else begin
          idx_d = idx_m1;
        end
      end

      // Hand the single result word to the output register.
      S_FIN: begin
        if (!ov_q) begin
          ov_d    = 1'b1;
          ost_d   = rs_st_q;
          osl_d   = rs_sl_q;
          oid_d   = '0;
          olast_d = 1'b1;
          st_d    = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      cnt_q  <= '0;
      ov_q   <= 1'b0;
      pv_q   <= 1'b0;
      drop_q <= '0;
      n_q    <= '0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      ov_q   <= ov_d;
      pv_q   <= pv_d;
      drop_q <= drop_d;
      n_q    <= n_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    dly_q   <= dly_d;
    sd_q    <= sd_d;
    nw_q    <= nw_d;
    cmd_q   <= cmd_d;
    rs_st_q <= rs_st_d;
    rs_sl_q <= rs_sl_d;
    psl_q   <= psl_d;
    pid_q   <= pid_d;
    ost_q   <= ost_d;
    osl_q   <= osl_d;
    oid_q   <= oid_d;
    olast_q <= olast_d;
  end

  // The queue never holds more than its capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("task count above capacity");

  // Memory writes stay below the task count plus one slot of growth.
  a_wr_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (IW'(waddr) <= cnt_q) && (IW'(waddr) < CNT_MAX))
    else $error("memory write outside the queue");

  // A dispatch never produces more words than allowed.
  a_disp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(dlts_pkg::MaxResults))
    else $error("dispatch word count overflow");

  // A delete of a slot at or beyond the count is refused and leaves the count.
  a_bad_del: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.cmd == dlts_pkg::CMD_DEL && 8'(in_i.slot) >= 8'(cnt_q)
    |=> rs_st_q == dlts_pkg::ST_BAD && $stable(cnt_q))
    else $error("bad delete not refused");

  // A new command is only taken with no word held back.
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !pv_q)
    else $error("command accepted with a pending dispatch word");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench for the delta-list task scheduler.
// Depends on dlts_pkg, dlts_if.sv and delta_list_task_scheduler_unit.
`default_nettype none

module testbench;

  localparam int unsigned NTasks = dlts_pkg::MaxTasksDef;
  localparam int unsigned LimitCycles = 400000;

  typedef struct packed {
    logic [dlts_pkg::StatW-1:0] status;
    logic [dlts_pkg::SlotW-1:0] slot_out;
    logic [dlts_pkg::IdW-1:0]   run_id;
    logic                       last;
  } sched_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  dlts_in_if  in_ch();
  dlts_out_if out_ch();

  delta_list_task_scheduler_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // Shadow copy of the timer queue.
  logic [dlts_pkg::IdW-1:0]    q_task   [NTasks];
  logic [dlts_pkg::InDlyW-1:0] q_delta  [NTasks];
  logic [dlts_pkg::InDlyW-1:0] q_period [NTasks];
  logic [dlts_pkg::RunsW-1:0]  q_runs   [NTasks];
  int unsigned                 q_count;

  sched_word_t expected_words[$];
  int          error_count = 0;
  int unsigned cycle_count = 0;
  bit          allow_idle = 1'b1;

  // Remove the entry at pos, folding its delta into the successor.
  function automatic void q_remove(int unsigned pos);
    int unsigned i;
    logic [dlts_pkg::InDlyW:0] sum;
    if (pos >= q_count) return;
    if (pos + 1 < q_count) begin
      sum = q_delta[pos+1] + q_delta[pos];
      q_delta[pos+1] = sum[dlts_pkg::InDlyW] ? '1 : sum[dlts_pkg::InDlyW-1:0];
    end
    for (i = pos; i + 1 < q_count; i++) begin
      q_task[i] = q_task[i+1];
      q_delta[i] = q_delta[i+1];
      q_period[i] = q_period[i+1];
      q_runs[i] = q_runs[i+1];
    end
    q_task[i] = '0;
    q_delta[i] = '0;
    q_period[i] = '0;
    q_runs[i] = '0;
    q_count--;
  endfunction

  // Insert in due order behind entries due at the same time.
  function automatic int unsigned q_insert(logic [dlts_pkg::IdW-1:0] id,
                                           logic [dlts_pkg::InDlyW-1:0] d,
                                           logic [dlts_pkg::InDlyW-1:0] p,
                                           logic [dlts_pkg::RunsW-1:0] r);
    int unsigned pos;
    pos = 0;
    while (pos < q_count && d >= q_delta[pos]) begin
      d -= q_delta[pos];
      pos++;
    end
    for (int unsigned i = q_count; i > pos; i--) begin
      q_task[i] = q_task[i-1];
      q_delta[i] = q_delta[i-1];
      q_period[i] = q_period[i-1];
      q_runs[i] = q_runs[i-1];
    end
    if (pos < q_count) q_delta[pos+1] -= d;
    q_task[pos] = id;
    q_delta[pos] = d;
    q_period[pos] = p;
    q_runs[pos] = r;
    q_count++;
    return pos;
  endfunction

  function automatic void push_word(logic [dlts_pkg::StatW-1:0] st, int unsigned sl,
                                    logic [dlts_pkg::IdW-1:0] id, logic lst);
    sched_word_t w;
    w.status = st;
    w.slot_out = sl[dlts_pkg::SlotW-1:0];
    w.run_id = id;
    w.last = lst;
    expected_words.push_back(w);
  endfunction

  // Work out the result words of one accepted command.
  function automatic void predict_schedule(logic [dlts_pkg::CmdW-1:0] cmd,
                                           logic [dlts_pkg::IdW-1:0] id,
                                           logic [dlts_pkg::InDlyW-1:0] d,
                                           logic [dlts_pkg::InDlyW-1:0] p,
                                           logic [dlts_pkg::SlotW-1:0] sl);
    int unsigned h, n, pos;
    bit drop [NTasks];
    logic [dlts_pkg::IdW-1:0] rid;
    logic [dlts_pkg::InDlyW-1:0] rp;
    logic [dlts_pkg::RunsW-1:0] rr;
    case (cmd)
      dlts_pkg::CMD_TICK: begin
        h = 0;
        while (h < q_count && q_period[h] == 0 && q_runs[h] != 0) h++;
        if (h < q_count) begin
          if (q_delta[h] != 0) begin
            q_delta[h]--;
          end else begin
            if (q_runs[h] != '1) q_runs[h]++;
            if (q_period[h] != 0) begin
              rid = q_task[h];
              rp = q_period[h];
              rr = q_runs[h];
              q_remove(h);
              void'(q_insert(rid, rp, rp, rr));
            end
          end
        end
        push_word(dlts_pkg::ST_OK, 0, '0, 1'b1);
      end
      dlts_pkg::CMD_ADD: begin
        if (q_count >= NTasks) begin
          push_word(dlts_pkg::ST_FULL, 0, '0, 1'b1);
        end else begin
          pos = q_insert(id, d, p, '0);
          push_word(dlts_pkg::ST_OK, pos, '0, 1'b1);
        end
      end
      dlts_pkg::CMD_DEL: begin
        if (sl >= q_count) begin
          push_word(dlts_pkg::ST_BAD, 0, '0, 1'b1);
        end else begin
          q_remove(sl);
          push_word(dlts_pkg::ST_OK, 0, '0, 1'b1);
        end
      end
      default: begin
        n = 0;
        foreach (drop[i]) drop[i] = 1'b0;
        for (int unsigned i = 0; i < q_count && n < dlts_pkg::MaxResults; i++) begin
          if (q_runs[i] != 0) begin
            push_word(dlts_pkg::ST_OK, i, q_task[i], 1'b0);
            n++;
            q_runs[i]--;
            if (q_runs[i] == 0 && q_period[i] == 0) drop[i] = 1'b1;
          end
        end
        for (int unsigned i = q_count; i > 0; i--) begin
          if (drop[i-1]) q_remove(i - 1);
        end
        if (n == 0) push_word(dlts_pkg::ST_NONE, 0, '0, 1'b1);
        else expected_words[$].last = 1'b1;
      end
    endcase
  endfunction

  // Send one command word, with random idle bursts before it.
  task automatic send_command(logic [dlts_pkg::CmdW-1:0] cmd,
                              logic [dlts_pkg::IdW-1:0] id,
                              logic [dlts_pkg::InDlyW-1:0] d,
                              logic [dlts_pkg::InDlyW-1:0] p,
                              logic [dlts_pkg::SlotW-1:0] sl);
    int unsigned gap;
    gap = 0;
    if (allow_idle && $urandom_range(3) == 0) gap = $urandom_range(4, 1);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.task_id <= id;
    in_ch.delay <= d;
    in_ch.period <= p;
    in_ch.slot <= sl;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_schedule(cmd, id, d, p, sl);
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    go_idle();
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  // Receiver stalls in random bursts.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (allow_idle && $urandom_range(5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(4, 1) - 1) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    sched_word_t w;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        error_count++;
      end else begin
        w = expected_words.pop_front();
        if (out_ch.status !== w.status) begin
          $error("status expected %0d actual %0d", w.status, out_ch.status);
          error_count++;
        end
        if (out_ch.slot_out !== w.slot_out) begin
          $error("slot_out expected %0d actual %0d", w.slot_out, out_ch.slot_out);
          error_count++;
        end
        if (out_ch.run_id !== w.run_id) begin
          $error("run_id expected %0d actual %0d", w.run_id, out_ch.run_id);
          error_count++;
        end
        if (out_ch.last !== w.last) begin
          $error("last expected %0d actual %0d", w.last, out_ch.last);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Empty queue, bad slots, one-shot firing and the zero delay case.
  task automatic test_basic_cases();
    send_command(dlts_pkg::CMD_TICK, '0, '0, '0, '0);
    send_command(dlts_pkg::CMD_DISP, '0, '0, '0, '0);
    send_command(dlts_pkg::CMD_DEL, '0, '0, '0, 4'd0);
    send_command(dlts_pkg::CMD_DEL, '0, '0, '0, 4'd15);
    send_command(dlts_pkg::CMD_ADD, 8'hFF, 16'd0, 16'd0, '0);
    send_command(dlts_pkg::CMD_ADD, 8'h00, 16'hFFFF, 16'hFFFF, '0);
    send_command(dlts_pkg::CMD_ADD, 8'hA5, 16'd0, 16'd1, '0);
    send_command(dlts_pkg::CMD_TICK, '0, '0, '0, '0);
    send_command(dlts_pkg::CMD_TICK, '0, '0, '0, '0);
    send_command(dlts_pkg::CMD_DISP, '0, '0, '0, '0);
    send_command(dlts_pkg::CMD_DEL, '0, '0, '0, 4'd1);
    send_command(dlts_pkg::CMD_DEL, '0, '0, '0, 4'd0);
    send_command(dlts_pkg::CMD_DISP, '0, '0, '0, '0);
  endtask

  // Fill the queue, overflow it, and dispatch many ready tasks at once.
  task automatic test_full_queue();
    for (int i = 0; i < NTasks; i++)
      send_command(dlts_pkg::CMD_ADD, 8'(i + 1), 16'd0, 16'(i % 2), '0);
    send_command(dlts_pkg::CMD_ADD, 8'h55, 16'd3, 16'd3, '0);
    repeat (20) send_command(dlts_pkg::CMD_TICK, '0, '0, '0, '0);
    send_command(dlts_pkg::CMD_DISP, '0, '0, '0, '0);
    send_command(dlts_pkg::CMD_DISP, '0, '0, '0, '0);
    wait_drained();
    while (q_count != 0)
      send_command(dlts_pkg::CMD_DEL, '0, '0, '0, 4'($urandom_range(q_count - 1)));
  endtask

  // Random mix weighted toward ticks with short delays.
  task automatic test_random_mix(int unsigned count);
    logic [dlts_pkg::CmdW-1:0] cmd;
    logic [dlts_pkg::InDlyW-1:0] d, p;
    for (int unsigned k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: cmd = dlts_pkg::CMD_TICK;
        4, 5:       cmd = dlts_pkg::CMD_ADD;
        6:          cmd = dlts_pkg::CMD_DEL;
        default:    cmd = dlts_pkg::CMD_DISP;
      endcase
      d = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(6));
      p = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(4));
      send_command(cmd, 8'($urandom), d, p, 4'($urandom));
      if (k == count / 2) wait_drained();
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = dlts_pkg::CMD_TICK;
    in_ch.task_id = '0;
    in_ch.delay = '0;
    in_ch.period = '0;
    in_ch.slot = '0;
    q_count = 0;
    foreach (q_task[i]) begin
      q_task[i] = '0;
      q_delta[i] = '0;
      q_period[i] = '0;
      q_runs[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_cases();
    test_full_queue();
    test_random_mix(150);
    allow_idle = 1'b0;
    test_random_mix(30);
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
